@@ hdl/pdd_pkg.sv @@
package pdd_pkg;

  localparam int unsigned BCD_DIGITS  = 14;
  localparam int unsigned BCD_W       = 4 * BCD_DIGITS;
  localparam int unsigned DAB_STAGES  = 8;
  localparam int unsigned PIPE_STAGES = DAB_STAGES + 2;

  localparam logic [13:0] YEAR_LO   = 14'd1990;
  localparam logic [13:0] YEAR_HI   = 14'd2100;
  localparam logic [16:0] MONTHS_YR = 17'd13;
  // floor(ym / 13) == (ym * PK_RECIP) >> PK_SHIFT for every 17-bit ym
  localparam logic [20:0] PK_RECIP  = 21'd1290556;
  localparam int unsigned PK_SHIFT  = 24;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_LEGACY = 2'd1,
    KIND_PACKED = 2'd2
  } pdd_kind_e;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } pdd_dt_t;

  typedef struct packed {
    logic [63:0]      word;
    logic [BCD_W-1:0] bcd;
    logic [13:0]      pk_year;
  } pdd_dab_t;

  typedef struct packed {
    pdd_dt_t     leg;
    pdd_dt_t     pk;
    logic        sign;
    logic [23:0] low;
  } pdd_fld_t;

  // one shift-add-3 step over the low BCD_DIGITS digits
  function automatic logic [BCD_W-1:0] dab_step(input logic [BCD_W-1:0] b, input logic din);
    logic [BCD_W-1:0] t;
    t = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[BCD_W-2:0], din};
  endfunction

  function automatic logic [BCD_W-1:0] dab_byte(input logic [BCD_W-1:0] b, input logic [7:0] d);
    logic [BCD_W-1:0] t;
    t = b;
    for (int j = 0; j < 8; j++) begin
      t = dab_step(t, d[3'(7 - j)]);
    end
    return t;
  endfunction

  function automatic logic [6:0] bcd2(input logic [7:0] d);
    return 7'(d[7:4]) * 7'd10 + 7'(d[3:0]);
  endfunction

  function automatic logic [13:0] bcd4(input logic [15:0] d);
    return 14'(d[15:12]) * 14'd1000 + 14'(d[11:8]) * 14'd100 +
           14'(d[7:4]) * 14'd10 + 14'(d[3:0]);
  endfunction

  function automatic logic dt_valid(input pdd_dt_t f);
    return (f.year > YEAR_LO) && (f.year < YEAR_HI) &&
           (f.month >= 7'd1) && (f.month <= 7'd12) &&
           (f.day >= 7'd1) && (f.day <= 7'd31) &&
           (f.hour <= 7'd23) && (f.minute <= 7'd59) && (f.second <= 7'd59);
  endfunction

endpackage

@@ hdl/packed_datetime_decoder.sv @@
// Channel | Direction | Handshake          | Payload
// cfg     | in        | cfg_we_i           | cfg_wdata_i (frac_bytes)
// in      | in        | valid_i / ready_o  | raw_word_i
// out     | out       | valid_o / ready_i  | year_o .. second_o, fraction_o, format_kind_o
//
// One word per cycle sustained while ready_i stays high; valid_o comes from the last stage.
// Eight stages convert the 63-bit legacy value to BCD, eight bits per stage; one stage
// forms both field sets, one stage checks ranges, selects and holds the result.
// Each stage holds its item on a stall and refills behind a bubble, so input flows while
// a result waits, until all stages fill. Reset clears stage valids and frac_bytes.
module packed_datetime_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] raw_word_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [13:0] year_o,
  output logic [6:0]  month_o,
  output logic [6:0]  day_o,
  output logic [6:0]  hour_o,
  output logic [6:0]  minute_o,
  output logic [6:0]  second_o,
  output logic [23:0] fraction_o,
  output logic [1:0]  format_kind_o
);

  logic [1:0] frac_bytes_q;

  logic [pdd_pkg::PIPE_STAGES-1:0] v_q;
  logic [pdd_pkg::PIPE_STAGES-1:0] en;

  pdd_pkg::pdd_dab_t dab_q [pdd_pkg::DAB_STAGES];
  pdd_pkg::pdd_dab_t dab_d [pdd_pkg::DAB_STAGES];
  pdd_pkg::pdd_fld_t fld_q, fld_d;

  pdd_pkg::pdd_dt_t   out_dt_q, out_dt_d;
  logic [23:0]        frac_q, frac_d;
  pdd_pkg::pdd_kind_e kind_q, kind_d;

  logic [37:0] pk_prod;
  logic [16:0] ym;
  logic [16:0] pk_mo;
  logic        leg_ok, pk_ok;

  // stall chain: a stage loads when empty or when its successor loads
  always_comb begin
    en[pdd_pkg::PIPE_STAGES-1] = !v_q[pdd_pkg::PIPE_STAGES-1] || ready_i;
    for (int k = pdd_pkg::PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  // BCD conversion stages, sign bit left out of the conversion on entry
  always_comb begin
    pk_prod          = 38'(raw_word_i[62:46]) * 38'(pdd_pkg::PK_RECIP);
    dab_d[0].word    = raw_word_i;
    dab_d[0].bcd     = pdd_pkg::dab_byte('0, {1'b0, raw_word_i[62:56]});
    dab_d[0].pk_year = pk_prod[pdd_pkg::PK_SHIFT +: 14];
    for (int k = 1; k < pdd_pkg::DAB_STAGES; k++) begin
      dab_d[k].word    = dab_q[k-1].word;
      dab_d[k].pk_year = dab_q[k-1].pk_year;
      dab_d[k].bcd     = pdd_pkg::dab_byte(dab_q[k-1].bcd,
                                           dab_q[k-1].word[8*(7-k) +: 8]);
    end
  end

  // field formation for both layouts
  always_comb begin
    ym    = dab_q[pdd_pkg::DAB_STAGES-1].word[62:46];
    pk_mo = ym - 17'(dab_q[pdd_pkg::DAB_STAGES-1].pk_year) * pdd_pkg::MONTHS_YR;

    fld_d.leg.second = pdd_pkg::bcd2(dab_q[pdd_pkg::DAB_STAGES-1].bcd[7:0]);
    fld_d.leg.minute = pdd_pkg::bcd2(dab_q[pdd_pkg::DAB_STAGES-1].bcd[15:8]);
    fld_d.leg.hour   = pdd_pkg::bcd2(dab_q[pdd_pkg::DAB_STAGES-1].bcd[23:16]);
    fld_d.leg.day    = pdd_pkg::bcd2(dab_q[pdd_pkg::DAB_STAGES-1].bcd[31:24]);
    fld_d.leg.month  = pdd_pkg::bcd2(dab_q[pdd_pkg::DAB_STAGES-1].bcd[39:32]);
    fld_d.leg.year   = pdd_pkg::bcd4(dab_q[pdd_pkg::DAB_STAGES-1].bcd[55:40]);

    fld_d.pk.year    = dab_q[pdd_pkg::DAB_STAGES-1].pk_year;
    fld_d.pk.month   = 7'(pk_mo[3:0]);
    fld_d.pk.day     = 7'(dab_q[pdd_pkg::DAB_STAGES-1].word[45:41]);
    fld_d.pk.hour    = 7'(dab_q[pdd_pkg::DAB_STAGES-1].word[40:36]);
    fld_d.pk.minute  = 7'(dab_q[pdd_pkg::DAB_STAGES-1].word[35:30]);
    fld_d.pk.second  = 7'(dab_q[pdd_pkg::DAB_STAGES-1].word[29:24]);

    fld_d.sign = dab_q[pdd_pkg::DAB_STAGES-1].word[63];
    fld_d.low  = dab_q[pdd_pkg::DAB_STAGES-1].word[23:0];
  end

  // range check and select; legacy wins
  always_comb begin
    leg_ok   = pdd_pkg::dt_valid(fld_q.leg);
    pk_ok    = fld_q.sign && pdd_pkg::dt_valid(fld_q.pk);
    out_dt_d = fld_q.leg;
    frac_d   = '0;
    kind_d   = pdd_pkg::KIND_NONE;
    if (leg_ok) begin
      kind_d = pdd_pkg::KIND_LEGACY;
    end else if (pk_ok) begin
      kind_d   = pdd_pkg::KIND_PACKED;
      out_dt_d = fld_q.pk;
      unique case (frac_bytes_q)
        2'd0: frac_d = '0;
        2'd1: frac_d = {16'd0, fld_q.low[23:16]};
        2'd2: frac_d = {8'd0, fld_q.low[23:8]};
        2'd3: frac_d = fld_q.low;
        default: frac_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_bytes_q <= '0;
      v_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        frac_bytes_q <= cfg_wdata_i;
      end
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < pdd_pkg::PIPE_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < pdd_pkg::DAB_STAGES; k++) begin
      if (en[k]) begin
        dab_q[k] <= dab_d[k];
      end
    end
    if (en[pdd_pkg::DAB_STAGES]) begin
      fld_q <= fld_d;
    end
    if (en[pdd_pkg::PIPE_STAGES-1]) begin
      out_dt_q <= out_dt_d;
      frac_q   <= frac_d;
      kind_q   <= kind_d;
    end
  end

  assign valid_o       = v_q[pdd_pkg::PIPE_STAGES-1];
  assign year_o        = out_dt_q.year;
  assign month_o       = out_dt_q.month;
  assign day_o         = out_dt_q.day;
  assign hour_o        = out_dt_q.hour;
  assign minute_o      = out_dt_q.minute;
  assign second_o      = out_dt_q.second;
  assign fraction_o    = frac_q;
  assign format_kind_o = kind_q;

endmodule

@@ hdl/pdd_checker.sv @@
module pdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_wdata_i,
  input logic        valid_i,
  input logic        ready_o,
  input logic [63:0] raw_word_i,
  input logic        valid_o,
  input logic        ready_i,
  input logic [13:0] year_o,
  input logic [6:0]  month_o,
  input logic [6:0]  day_o,
  input logic [6:0]  hour_o,
  input logic [6:0]  minute_o,
  input logic [6:0]  second_o,
  input logic [23:0] fraction_o,
  input logic [1:0]  format_kind_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(year_o) && $stable(format_kind_o))
    else $error("output dropped or changed while stalled");

  a_frac_packed_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (format_kind_o != pdd_pkg::KIND_PACKED) |-> fraction_o == 24'd0)
    else $error("fraction set outside packed format");

  a_legacy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (format_kind_o == pdd_pkg::KIND_LEGACY) |->
      year_o > pdd_pkg::YEAR_LO && year_o < pdd_pkg::YEAR_HI &&
      month_o >= 7'd1 && month_o <= 7'd12 && second_o <= 7'd59)
    else $error("legacy result out of range");

  a_packed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (format_kind_o == pdd_pkg::KIND_PACKED) |->
      day_o >= 7'd1 && day_o <= 7'd31 && hour_o <= 7'd23 && minute_o <= 7'd59)
    else $error("packed result out of range");

endmodule

bind packed_datetime_decoder pdd_checker u_pdd_checker (.*);

@@ verif/tb_packed_datetime_decoder.sv @@
`timescale 1ns / 1ps

import pdd_pkg::*;

typedef struct packed {
  pdd_dt_t     dt;
  logic [23:0] fraction;
  pdd_kind_e   kind;
} dt_result_t;

typedef struct {
  logic [63:0] word;
  dt_result_t  res;
} dt_pending_t;

class dt_scoreboard;
  logic [1:0]  frac_bytes;
  dt_pending_t expected_q[$];
  int          fail_count;

  function new();
    frac_bytes = '0;
    fail_count = 0;
  endfunction

  function void set_frac(logic [1:0] v);
    frac_bytes = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // decimal YYYYMMDDhhmmss, sign bit dropped, year is quotient mod 10000
  function pdd_dt_t split_decimal(logic [63:0] w);
    logic [63:0] r;
    pdd_dt_t     f;
    r = {1'b0, w[62:0]};
    f.second = 7'(r % 100); r = r / 100;
    f.minute = 7'(r % 100); r = r / 100;
    f.hour   = 7'(r % 100); r = r / 100;
    f.day    = 7'(r % 100); r = r / 100;
    f.month  = 7'(r % 100); r = r / 100;
    f.year   = 14'(r % 10000);
    return f;
  endfunction

  function pdd_dt_t split_bitpacked(logic [63:0] w);
    logic [16:0] ym;
    logic [31:0] yr;
    pdd_dt_t     f;
    ym       = w[62:46];
    yr       = ym / MONTHS_YR;
    f.year   = 14'(yr);
    f.month  = 7'(ym - yr * MONTHS_YR);
    f.day    = 7'(w[45:41]);
    f.hour   = 7'(w[40:36]);
    f.minute = 7'(w[35:30]);
    f.second = 7'(w[29:24]);
    return f;
  endfunction

  function bit in_window(pdd_dt_t f);
    return f.year > YEAR_LO && f.year < YEAR_HI &&
           f.month >= 1 && f.month <= 12 && f.day >= 1 && f.day <= 31 &&
           f.hour <= 23 && f.minute <= 59 && f.second <= 59;
  endfunction

  function void note_input(logic [63:0] w);
    dt_pending_t e;
    pdd_dt_t     pk;
    e.word         = w;
    e.res.dt       = split_decimal(w);
    e.res.fraction = '0;
    e.res.kind     = KIND_NONE;
    if (in_window(e.res.dt)) begin
      e.res.kind = KIND_LEGACY;
    end else if (w[63]) begin
      pk = split_bitpacked(w);
      if (in_window(pk)) begin
        e.res.dt   = pk;
        e.res.kind = KIND_PACKED;
        if (frac_bytes != 0) begin
          e.res.fraction = w[23:0] >> (24 - 8 * frac_bytes);
        end
      end
    end
    expected_q.push_back(e);
  endfunction

  task report(string msg);
    fail_count++;
    if (fail_count <= 50) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  task cmp(string name, logic [23:0] got, logic [23:0] exp, logic [63:0] w);
    if (got !== exp) begin
      report($sformatf("%s got %0d exp %0d word %h", name, got, exp, w));
    end
  endtask

  task check_result(dt_result_t got);
    dt_pending_t e;
    if (expected_q.size() == 0) begin
      report("result transfer with nothing outstanding");
    end else begin
      e = expected_q.pop_front();
      cmp("year", 24'(got.dt.year), 24'(e.res.dt.year), e.word);
      cmp("month", 24'(got.dt.month), 24'(e.res.dt.month), e.word);
      cmp("day", 24'(got.dt.day), 24'(e.res.dt.day), e.word);
      cmp("hour", 24'(got.dt.hour), 24'(e.res.dt.hour), e.word);
      cmp("minute", 24'(got.dt.minute), 24'(e.res.dt.minute), e.word);
      cmp("second", 24'(got.dt.second), 24'(e.res.dt.second), e.word);
      cmp("fraction", got.fraction, e.res.fraction, e.word);
      cmp("format_kind", 24'(got.kind), 24'(e.res.kind), e.word);
    end
  endtask
endclass

module tb_packed_datetime_decoder;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 14;
  localparam logic [63:0] SIGN_BIT    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TEN_E14     = 64'd100_000_000_000_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_wdata_i = '0;
  logic        valid_i     = 1'b0;
  logic        ready_o;
  logic [63:0] raw_word_i  = '0;
  logic        valid_o;
  logic        ready_i     = 1'b0;
  logic [13:0] year_o;
  logic [6:0]  month_o;
  logic [6:0]  day_o;
  logic [6:0]  hour_o;
  logic [6:0]  minute_o;
  logic [6:0]  second_o;
  logic [23:0] fraction_o;
  logic [1:0]  format_kind_o;

  dt_scoreboard sb;
  int unsigned  tx_max_gap  = 19;
  int unsigned  rx_max_gap  = 19;
  int unsigned  rx_hold     = 0;
  int unsigned  cycle_count = 0;

  packed_datetime_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_i       (valid_i),
    .ready_o       (ready_o),
    .raw_word_i    (raw_word_i),
    .valid_o       (valid_o),
    .ready_i       (ready_i),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_o         (day_o),
    .hour_o        (hour_o),
    .minute_o      (minute_o),
    .second_o      (second_o),
    .fraction_o    (fraction_o),
    .format_kind_o (format_kind_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] decimal_word(input int unsigned y, mo, d, h, mi, s);
    return 64'(y) * 64'd10_000_000_000 + 64'(mo) * 64'd100_000_000 +
           64'(d) * 64'd1_000_000 + 64'(h) * 64'd10_000 + 64'(mi) * 64'd100 + 64'(s);
  endfunction

  function automatic logic [63:0] bitpacked_word(input int unsigned ym, d, h, mi, s,
                                                 input logic [23:0] low);
    return {1'b1, 17'(ym), 5'(d), 5'(h), 6'(mi), 6'(s), low};
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned pick, y, mo, d, h, mi, s;
    logic [63:0] w;
    pick = $urandom_range(0, 99);
    y    = $urandom_range(1991, 2099);
    mo   = $urandom_range(1, 12);
    d    = $urandom_range(1, 31);
    h    = $urandom_range(0, 23);
    mi   = $urandom_range(0, 59);
    s    = $urandom_range(0, 59);
    if (pick < 30) begin
      if (pick < 10) begin
        case ($urandom_range(0, 5))
          0: y = $urandom_range(0, 9999);
          1: mo = $urandom_range(0, 99);
          2: d = $urandom_range(0, 99);
          3: h = $urandom_range(0, 99);
          4: mi = $urandom_range(0, 99);
          default: s = $urandom_range(0, 99);
        endcase
      end
      w = decimal_word(y, mo, d, h, mi, s);
      if ($urandom_range(0, 3) == 0) begin
        w = w + 64'($urandom_range(0, 92233)) * TEN_E14;
      end
      if ($urandom_range(0, 3) == 0) begin
        w[63] = 1'b1;
      end
    end else if (pick < 80) begin
      if (pick < 45) begin
        case ($urandom_range(0, 4))
          0: y = $urandom_range(0, 10082);
          1: d = $urandom_range(0, 31);
          2: h = $urandom_range(0, 31);
          3: mi = $urandom_range(0, 63);
          default: s = $urandom_range(0, 63);
        endcase
      end
      w = bitpacked_word(y * 13 + mo, d, h, mi, s, 24'($urandom));
      if (pick < 33) begin
        w[62:46] = 17'($urandom);
      end
    end else begin
      w = {$urandom, $urandom};
    end
    return w;
  endfunction

  // leaves valid high after the transfer; the next call or sender_idle follows at once
  task automatic send_word(input logic [63:0] w);
    int unsigned gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i    <= 1'b1;
    raw_word_i <= w;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    sb.note_input(w);
  endtask

  task automatic sender_idle();
    valid_i <= 1'b0;
  endtask

  task automatic drain();
    sender_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_frac(input logic [1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_frac(v);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_word(rand_word());
  endtask

  task automatic run_directed();
    send_word('0);
    send_word('1);
    send_word(SIGN_BIT);
    send_word(decimal_word(1991, 1, 1, 0, 0, 0));
    send_word(decimal_word(2099, 12, 31, 23, 59, 59));
    send_word(decimal_word(1990, 6, 15, 12, 0, 0));
    send_word(decimal_word(2100, 6, 15, 12, 0, 0));
    send_word(decimal_word(2020, 0, 15, 12, 0, 0));
    send_word(decimal_word(2020, 13, 32, 24, 60, 60));
    // legacy check runs first even with the sign bit set
    send_word(SIGN_BIT | decimal_word(2020, 2, 29, 8, 30, 0));
    // digits above the year drop out of the quotient
    send_word(64'd92233 * TEN_E14 + decimal_word(2042, 7, 4, 18, 5, 9));
    send_word(bitpacked_word(1991 * 13 + 1, 1, 0, 0, 0, 24'hABCDEF));
    send_word(bitpacked_word(2099 * 13 + 12, 31, 23, 59, 59, 24'hFFFFFF));
    send_word(bitpacked_word(2050 * 13 + 6, 15, 12, 30, 30, 24'h000000));
    send_word(bitpacked_word(2000 * 13, 10, 10, 10, 10, 24'h123456));
    send_word(bitpacked_word(2000 * 13 + 5, 0, 10, 10, 10, 24'h654321));
    send_word(bitpacked_word(2000 * 13 + 5, 10, 24, 10, 10, 24'h0F0F0F));
    send_word(bitpacked_word(2000 * 13 + 5, 10, 10, 60, 10, 24'hF0F0F0));
    send_word(bitpacked_word(2000 * 13 + 5, 10, 10, 10, 63, 24'h808080));
    send_word(bitpacked_word(1990 * 13 + 12, 10, 10, 10, 10, 24'h010203));
    send_word(bitpacked_word(2100 * 13 + 1, 10, 10, 10, 10, 24'h0A0B0C));
    send_word(~SIGN_BIT & bitpacked_word(2050 * 13 + 6, 15, 12, 30, 30, 24'h777777));
    send_word(bitpacked_word(17'h1FFFF, 31, 31, 63, 63, 24'hFFFFFF));
  endtask

  initial begin : receiver
    int unsigned stall;
    dt_result_t  got;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = $urandom_range(0, rx_max_gap);
      end
      if (stall > 0) begin
        ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      ready_i <= 1'b1;
      @(posedge clk_i);
      while (!valid_o) @(posedge clk_i);
      got.dt.year   = year_o;
      got.dt.month  = month_o;
      got.dt.day    = day_o;
      got.dt.hour   = hour_o;
      got.dt.minute = minute_o;
      got.dt.second = second_o;
      got.fraction  = fraction_o;
      got.kind      = pdd_kind_e'(format_kind_o);
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_frac(2'd3);
    run_directed();
    drain();

    write_frac(2'd0);
    run_random(150);
    drain();

    // back up the pipeline: receiver stalls long while words keep coming
    write_frac(2'd1);
    tx_max_gap = 0;
    rx_hold    = 400;
    run_random(60);
    tx_max_gap = 19;
    rx_max_gap = 5;
    run_random(90);
    drain();

    write_frac(2'd2);
    tx_max_gap = 0;
    rx_max_gap = 0;
    run_random(150);
    drain();

    write_frac(2'd3);
    tx_max_gap = 3;
    rx_max_gap = 19;
    run_random(75);
    tx_max_gap = 19;
    rx_max_gap = 2;
    run_random(75);
    drain();

    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pdd_pkg.sv
hdl/packed_datetime_decoder.sv
hdl/pdd_checker.sv
verif/tb_packed_datetime_decoder.sv
